FILE: hw/rtl/assert_macros.svh
// assertion helpers used by the checker file psu_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold on every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// antecedent implies consequent, checked outside reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// antecedent implies consequent in the next cycle, also checked during reset
`define ASSERT_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: hw/rtl/psu_pkg.sv
`timescale 1ns / 1ps
package psu_pkg;

   localparam int MAX_WIDTH   = 4096;
   localparam int MAX_BPP     = 4;
   localparam int STORE_DEPTH = MAX_WIDTH * MAX_BPP;
   localparam int IDX_W       = $clog2(STORE_DEPTH);
   localparam int LEN_W       = $clog2(STORE_DEPTH + 1);
   localparam int BPP_W       = $clog2(MAX_BPP + 1);
   localparam int SEL_W       = (MAX_BPP > 1) ? $clog2(MAX_BPP) : 1;
   localparam int BYTE_W      = 8;
   localparam int BPP_RAW_W   = 3;
   localparam int WIDTH_W     = 13;
   localparam int HEIGHT_W    = 16;
   localparam int ADDR_W      = 4;
   localparam int DATA_W      = 32;

   localparam logic [ADDR_W-1:0] ADDR_BPP    = 4'h0;
   localparam logic [ADDR_W-1:0] ADDR_WIDTH  = 4'h4;
   localparam logic [ADDR_W-1:0] ADDR_HEIGHT = 4'h8;

   localparam logic [BYTE_W-1:0] FILT_NONE  = 8'd0;
   localparam logic [BYTE_W-1:0] FILT_SUB   = 8'd1;
   localparam logic [BYTE_W-1:0] FILT_UP    = 8'd2;
   localparam logic [BYTE_W-1:0] FILT_AVG   = 8'd3;
   localparam logic [BYTE_W-1:0] FILT_PAETH = 8'd4;

   typedef struct packed {
      logic [BPP_W-1:0]    bpp;
      logic [LEN_W-1:0]    row_len;
      logic [HEIGHT_W-1:0] height;
   } cfg_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic [BYTE_W-1:0] filter;
      logic [IDX_W-1:0]  idx;
      logic              first_row;
      logic              row_end;
      logic              image_end;
   } stage_type;

   function automatic logic [BYTE_W-1:0] paeth(input logic [BYTE_W-1:0] a,
                                               input logic [BYTE_W-1:0] b,
                                               input logic [BYTE_W-1:0] c);
      logic [BYTE_W+1:0] pa;
      logic [BYTE_W+1:0] pb;
      logic [BYTE_W+1:0] pc;
      logic [BYTE_W+1:0] sab;
      logic [BYTE_W+1:0] c2;
      pa  = (b > c) ? {2'b00, b - c} : {2'b00, c - b};
      pb  = (a > c) ? {2'b00, a - c} : {2'b00, c - a};
      sab = {2'b00, a} + {2'b00, b};
      c2  = {1'b0, c, 1'b0};
      pc  = (sab > c2) ? (sab - c2) : (c2 - sab);
      if ((pa <= pb) && (pa <= pc)) begin
         return a;
      end else if (pb <= pc) begin
         return b;
      end
      return c;
   endfunction

endpackage

FILE: hw/rtl/png_scanline_unfilter.sv
`timescale 1ns / 1ps
// png scanline unfilter
// req channel: one filtered byte per request; the first byte of every row is
// the filter type and yields no response, each later byte yields one response
// rsp channel: reconstructed byte with row end on tlast and image end and
// bad filter flags on tuser
// csr port: bytes per pixel, width in pixels and height in rows at 0x0, 0x4
// and 0x8; write only while no request is in flight
// a data byte is registered into the s1 stage with its line store read, then
// reconstructed into the rsp output register, where it can be taken; a filter
// byte only sets the filter of its row
// throughput: one request per cycle in any mix of filter and data bytes while
// rsp is not stalled, set by the line store read and the predictor loop from
// each result to the next pixel's left neighbour
// reset: registers return to 4 bytes per pixel, width 1, height 1, and the
// block waits for the filter byte of a first row; the line store is not
// cleared, the row above the first row reads as zero
// a stalled rsp holds its byte, one more data byte waits in the pipeline and
// req_tready then drops for data bytes until rsp_tready returns
module png_scanline_unfilter (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [7:0]                  req_tdata,   // [7:0] filtered_byte
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [7:0]                  rsp_tdata,   // [7:0] pixel_byte
   output logic                        rsp_tlast,
   output logic [1:0]                  rsp_tuser,   // [0] image_end, [1] bad_filter
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [psu_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [psu_pkg::DATA_W-1:0]  csr_pwdata,
   output logic [psu_pkg::DATA_W-1:0]  csr_prdata,
   output logic                        csr_pready
);

   psu_pkg::cfg_type                cfg;
   psu_pkg::stage_type              stage;
   logic                            s1_ready;
   logic                            accept;
   logic                            data_accept;
   logic                            filt_accept;
   logic                            row_end;
   logic                            last_row;
   logic [psu_pkg::BYTE_W-1:0]      rd_data;
   logic                            wr_en;
   logic [psu_pkg::IDX_W-1:0]       wr_addr;
   logic [psu_pkg::BYTE_W-1:0]      wr_data;
   logic                            expect_filt_ff;
   logic                            expect_filt_in;
   logic [psu_pkg::BYTE_W-1:0]      filter_ff;
   logic [psu_pkg::BYTE_W-1:0]      filter_in;
   logic [psu_pkg::IDX_W-1:0]       idx_ff;
   logic [psu_pkg::IDX_W-1:0]       idx_in;
   logic [psu_pkg::HEIGHT_W-1:0]    row_count_ff;
   logic [psu_pkg::HEIGHT_W-1:0]    row_count_in;
   logic                            first_row_ff;
   logic                            first_row_in;
   logic [psu_pkg::LEN_W-1:0]       idx_next;
   logic [psu_pkg::HEIGHT_W:0]      row_next;

   psu_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   assign req_tready  = expect_filt_ff | s1_ready;
   assign accept      = req_tvalid & req_tready;
   assign filt_accept = accept & expect_filt_ff;
   assign data_accept = accept & ~expect_filt_ff;

   assign idx_next = psu_pkg::LEN_W'(idx_ff) + psu_pkg::LEN_W'(1);
   assign row_next = {1'b0, row_count_ff} + (psu_pkg::HEIGHT_W+1)'(1);
   assign row_end  = idx_next >= cfg.row_len;
   assign last_row = row_next >= {1'b0, cfg.height};

   always_comb begin
      expect_filt_in = expect_filt_ff;
      filter_in      = filter_ff;
      idx_in         = idx_ff;
      row_count_in   = row_count_ff;
      first_row_in   = first_row_ff;
      if (filt_accept) begin
         expect_filt_in = 1'b0;
         filter_in      = req_tdata;
         idx_in         = '0;
      end else if (data_accept) begin
         if (row_end) begin
            expect_filt_in = 1'b1;
            if (last_row) begin
               row_count_in = '0;
               first_row_in = 1'b1;
            end else begin
               row_count_in = row_next[psu_pkg::HEIGHT_W-1:0];
               first_row_in = 1'b0;
            end
         end else begin
            idx_in = idx_next[psu_pkg::IDX_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expect_filt_ff <= 1'b1;
         filter_ff      <= '0;
         idx_ff         <= '0;
         row_count_ff   <= '0;
         first_row_ff   <= 1'b1;
      end else begin
         expect_filt_ff <= expect_filt_in;
         filter_ff      <= filter_in;
         idx_ff         <= idx_in;
         row_count_ff   <= row_count_in;
         first_row_ff   <= first_row_in;
      end
   end

   assign stage.data      = req_tdata;
   assign stage.filter    = filter_ff;
   assign stage.idx       = idx_ff;
   assign stage.first_row = first_row_ff;
   assign stage.row_end   = row_end;
   assign stage.image_end = row_end & last_row;

   psu_line_store u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (data_accept),
      .rd_addr (idx_ff),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   psu_recon u_recon (
      .clock      (clock),
      .reset      (reset),
      .bpp        (cfg.bpp),
      .in_valid   (data_accept),
      .in_stage   (stage),
      .in_ready   (s1_ready),
      .rd_data    (rd_data),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

FILE: hw/rtl/psu_csr.sv
`timescale 1ns / 1ps
module psu_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [psu_pkg::ADDR_W-1:0]   csr_paddr,
   input  logic [psu_pkg::DATA_W-1:0]   csr_pwdata,
   output logic [psu_pkg::DATA_W-1:0]   csr_prdata,
   output logic                         csr_pready,
   output psu_pkg::cfg_type             cfg
);

   logic [psu_pkg::BPP_RAW_W-1:0] bpp_ff;
   logic [psu_pkg::BPP_RAW_W-1:0] bpp_in;
   logic [psu_pkg::WIDTH_W-1:0]   width_ff;
   logic [psu_pkg::WIDTH_W-1:0]   width_in;
   logic [psu_pkg::HEIGHT_W-1:0]  height_ff;
   logic [psu_pkg::HEIGHT_W-1:0]  height_in;
   logic                          wr_en;
   logic [psu_pkg::BPP_W-1:0]     bpp_eff;
   logic [psu_pkg::WIDTH_W-1:0]   width_eff;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      bpp_in    = bpp_ff;
      width_in  = width_ff;
      height_in = height_ff;
      if (wr_en) begin
         unique case (csr_paddr)
            psu_pkg::ADDR_BPP:    bpp_in    = csr_pwdata[psu_pkg::BPP_RAW_W-1:0];
            psu_pkg::ADDR_WIDTH:  width_in  = csr_pwdata[psu_pkg::WIDTH_W-1:0];
            psu_pkg::ADDR_HEIGHT: height_in = csr_pwdata[psu_pkg::HEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff    <= psu_pkg::BPP_RAW_W'(4);
         width_ff  <= psu_pkg::WIDTH_W'(1);
         height_ff <= psu_pkg::HEIGHT_W'(1);
      end else begin
         bpp_ff    <= bpp_in;
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   always_comb begin
      unique case (csr_paddr)
         psu_pkg::ADDR_BPP:    csr_prdata = psu_pkg::DATA_W'(bpp_ff);
         psu_pkg::ADDR_WIDTH:  csr_prdata = psu_pkg::DATA_W'(width_ff);
         psu_pkg::ADDR_HEIGHT: csr_prdata = psu_pkg::DATA_W'(height_ff);
         default:              csr_prdata = '0;
      endcase
   end

   // out-of-range bytes per pixel and width settings clamp
   always_comb begin
      if (bpp_ff == '0) begin
         bpp_eff = psu_pkg::BPP_W'(1);
      end else if (psu_pkg::BPP_W'(bpp_ff) > psu_pkg::BPP_W'(psu_pkg::MAX_BPP)) begin
         bpp_eff = psu_pkg::BPP_W'(psu_pkg::MAX_BPP);
      end else begin
         bpp_eff = psu_pkg::BPP_W'(bpp_ff);
      end
      if (width_ff == '0) begin
         width_eff = psu_pkg::WIDTH_W'(1);
      end else if (width_ff > psu_pkg::WIDTH_W'(psu_pkg::MAX_WIDTH)) begin
         width_eff = psu_pkg::WIDTH_W'(psu_pkg::MAX_WIDTH);
      end else begin
         width_eff = width_ff;
      end
   end

   assign cfg.bpp     = bpp_eff;
   assign cfg.row_len = psu_pkg::LEN_W'(width_eff) * psu_pkg::LEN_W'(bpp_eff);
   assign cfg.height  = height_ff;

endmodule

FILE: hw/rtl/psu_line_store.sv
`timescale 1ns / 1ps
module psu_line_store (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        rd_en,
   input  logic [psu_pkg::IDX_W-1:0]   rd_addr,
   output logic [psu_pkg::BYTE_W-1:0]  rd_data,
   input  logic                        wr_en,
   input  logic [psu_pkg::IDX_W-1:0]   wr_addr,
   input  logic [psu_pkg::BYTE_W-1:0]  wr_data
);

   logic [psu_pkg::BYTE_W-1:0] store_ff [psu_pkg::STORE_DEPTH];
   logic [psu_pkg::BYTE_W-1:0] rdata_ff;
   logic [psu_pkg::BYTE_W-1:0] byp_data_ff;
   logic                       byp_ff;
   logic                       byp_in;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff    <= store_ff[rd_addr];
         byp_data_ff <= wr_data;
      end
   end

   // same entry written and read on one edge: take the new byte
   assign byp_in = rd_en ? (wr_en && (wr_addr == rd_addr)) : byp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         byp_ff <= 1'b0;
      end else begin
         byp_ff <= byp_in;
      end
   end

   assign rd_data = byp_ff ? byp_data_ff : rdata_ff;

endmodule

FILE: hw/rtl/psu_recon.sv
`timescale 1ns / 1ps
module psu_recon (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [psu_pkg::BPP_W-1:0]   bpp,
   input  logic                        in_valid,
   input  psu_pkg::stage_type          in_stage,
   output logic                        in_ready,
   input  logic [psu_pkg::BYTE_W-1:0]  rd_data,
   output logic                        wr_en,
   output logic [psu_pkg::IDX_W-1:0]   wr_addr,
   output logic [psu_pkg::BYTE_W-1:0]  wr_data,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [7:0]                  rsp_tdata,
   output logic                        rsp_tlast,
   output logic [1:0]                  rsp_tuser
);

   psu_pkg::stage_type         s1_ff;
   logic                       s1_valid_ff;
   logic                       s1_valid_in;
   logic                       out_valid_ff;
   logic                       out_valid_in;
   logic [psu_pkg::BYTE_W-1:0] out_data_ff;
   logic                       out_last_ff;
   logic [1:0]                 out_user_ff;
   logic [psu_pkg::BYTE_W-1:0] left_ff [psu_pkg::MAX_BPP];
   logic [psu_pkg::BYTE_W-1:0] upleft_ff [psu_pkg::MAX_BPP];
   logic                       fire;
   logic [psu_pkg::BPP_W-1:0]  bpp_m1;
   logic [psu_pkg::SEL_W-1:0]  sel;
   logic                       has_left;
   logic [psu_pkg::BYTE_W-1:0] a;
   logic [psu_pkg::BYTE_W-1:0] b;
   logic [psu_pkg::BYTE_W-1:0] c;
   logic [psu_pkg::BYTE_W:0]   sum_ab;
   logic [psu_pkg::BYTE_W-1:0] pred;
   logic                       bad;
   logic [psu_pkg::BYTE_W-1:0] res;

   assign fire        = s1_valid_ff & (~out_valid_ff | rsp_tready);
   assign in_ready    = ~s1_valid_ff | fire;
   assign s1_valid_in = in_valid | (s1_valid_ff & ~fire);
   assign out_valid_in = fire | (out_valid_ff & ~rsp_tready);

   // neighbours exist only once a full pixel of this row is behind
   assign bpp_m1   = bpp - psu_pkg::BPP_W'(1);
   assign sel      = bpp_m1[psu_pkg::SEL_W-1:0];
   assign has_left = s1_ff.idx >= psu_pkg::IDX_W'(bpp);
   assign a        = has_left ? left_ff[sel] : '0;
   assign c        = has_left ? upleft_ff[sel] : '0;
   assign b        = s1_ff.first_row ? '0 : rd_data;
   assign sum_ab   = {1'b0, a} + {1'b0, b};

   always_comb begin
      bad = 1'b0;
      case (s1_ff.filter)
         psu_pkg::FILT_NONE:  pred = '0;
         psu_pkg::FILT_SUB:   pred = a;
         psu_pkg::FILT_UP:    pred = b;
         psu_pkg::FILT_AVG:   pred = sum_ab[psu_pkg::BYTE_W:1];
         psu_pkg::FILT_PAETH: pred = psu_pkg::paeth(a, b, c);
         default: begin
            pred = '0;
            bad  = 1'b1;
         end
      endcase
   end

   assign res     = s1_ff.data + pred;
   assign wr_en   = fire;
   assign wr_addr = s1_ff.idx;
   assign wr_data = res;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid) begin
         s1_ff <= in_stage;
      end
      if (fire) begin
         out_data_ff <= res;
         out_last_ff <= s1_ff.row_end;
         out_user_ff <= {bad, s1_ff.image_end};
         left_ff[0]   <= res;
         upleft_ff[0] <= b;
         for (int i = 1; i < psu_pkg::MAX_BPP; i++) begin
            left_ff[i]   <= left_ff[i-1];
            upleft_ff[i] <= upleft_ff[i-1];
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_user_ff;

endmodule

FILE: hw/rtl/psu_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module psu_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_tvalid,
   input logic                        rsp_tready,
   input logic [7:0]                  rsp_tdata,
   input logic                        rsp_tlast,
   input logic [1:0]                  rsp_tuser,
   input logic                        csr_pready
);

   `ASSERT_NEXT(a_reset_empties_rsp, clock, reset, !rsp_tvalid)
   `ASSERT_IMPLY(a_image_end_ends_row, clock, reset, rsp_tvalid && rsp_tuser[0], rsp_tlast)
   `ASSERT_IMPLY(a_rsp_stall_holds, clock, reset, $past(rsp_tvalid && !rsp_tready) && !$past(reset), rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
   `ASSERT_ALWAYS(a_csr_ready, clock, reset, csr_pready)

endmodule

bind png_scanline_unfilter psu_checker u_psu_checker (.*);

FILE: sim/testbench.sv
`timescale 1ns / 1ps
module testbench;

   localparam int LIMIT_CYCLES    = 2_000_000;
   localparam int DRAIN_CYCLES    = 10_000;
   localparam int SETTLE_CYCLES   = 4;
   localparam int RANDOM_REQUESTS = 1800;
   localparam int CALM_FROM       = 1500;
   localparam int PRINT_CAP       = 50;
   localparam int PREFILL_BYTES   = 64;

   typedef struct packed {
      logic [psu_pkg::BYTE_W-1:0] pixel;
      logic                       row_end;
      logic                       image_end;
      logic                       bad_filter;
   } pixel_type;

   typedef enum logic [1:0] {ROW_CSR, ROW_BYTE, ROW_CHECKED} row_kind_type;

   typedef struct {
      row_kind_type               kind;
      logic [psu_pkg::ADDR_W-1:0] addr;
      logic [psu_pkg::DATA_W-1:0] value;
      logic [psu_pkg::BYTE_W-1:0] data;
      pixel_type                  want;
   } stim_row_type;

   logic                         clock       = 1'b0;
   logic                         reset       = 1'b1;
   logic                         req_tvalid  = 1'b0;
   logic                         req_tready;
   logic [7:0]                   req_tdata   = '0;
   logic                         rsp_tvalid;
   logic                         rsp_tready  = 1'b1;
   logic [7:0]                   rsp_tdata;
   logic                         rsp_tlast;
   logic [1:0]                   rsp_tuser;
   logic                         csr_psel    = 1'b0;
   logic                         csr_penable = 1'b0;
   logic                         csr_pwrite  = 1'b0;
   logic [psu_pkg::ADDR_W-1:0]   csr_paddr   = '0;
   logic [psu_pkg::DATA_W-1:0]   csr_pwdata  = '0;
   logic [psu_pkg::DATA_W-1:0]   csr_prdata;
   logic                         csr_pready;

   png_scanline_unfilter dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // reconstruction state mirrored by the testbench
   logic [psu_pkg::BYTE_W-1:0]    line_store [psu_pkg::STORE_DEPTH];
   logic [psu_pkg::BYTE_W-1:0]    left_hist [psu_pkg::MAX_BPP];
   logic [psu_pkg::BYTE_W-1:0]    upleft_hist [psu_pkg::MAX_BPP];
   logic [psu_pkg::BYTE_W-1:0]    row_filter;
   int unsigned                   byte_pos;
   int unsigned                   row_count;
   bit                            first_row;
   logic [psu_pkg::BPP_RAW_W-1:0] bpp_reg;
   logic [psu_pkg::WIDTH_W-1:0]   width_reg;
   logic [psu_pkg::HEIGHT_W-1:0]  height_reg;

   pixel_type   pending_pixels [$];
   pixel_type   want_pixel;
   int unsigned error_count       = 0;
   int unsigned sent_requests     = 0;
   int unsigned random_requests   = 0;
   int unsigned checked_responses = 0;
   int unsigned csr_writes        = 0;
   int unsigned cycle_count       = 0;
   int unsigned stall_left        = 0;
   int unsigned req_gap_pct       = 20;
   int unsigned rsp_stall_pct     = 20;
   bit          calm              = 1'b0;

   // reset configuration gives rows of four bytes in a one-row image
   stim_row_type directed_stim [27] = '{
      '{ROW_BYTE,    psu_pkg::ADDR_BPP,    32'd0, psu_pkg::FILT_NONE,  '0},
      '{ROW_CHECKED, psu_pkg::ADDR_BPP,    32'd0, 8'h00, '{8'h00, 1'b0, 1'b0, 1'b0}},
      '{ROW_CHECKED, psu_pkg::ADDR_BPP,    32'd0, 8'hff, '{8'hff, 1'b0, 1'b0, 1'b0}},
      '{ROW_CHECKED, psu_pkg::ADDR_BPP,    32'd0, 8'h01, '{8'h01, 1'b0, 1'b0, 1'b0}},
      '{ROW_CHECKED, psu_pkg::ADDR_BPP,    32'd0, 8'h80, '{8'h80, 1'b1, 1'b1, 1'b0}},
      '{ROW_CSR,     psu_pkg::ADDR_BPP,    32'd1, 8'h00, '0},
      '{ROW_CSR,     psu_pkg::ADDR_WIDTH,  32'd2, 8'h00, '0},
      '{ROW_CSR,     psu_pkg::ADDR_HEIGHT, 32'd4, 8'h00, '0},
      '{ROW_BYTE,    psu_pkg::ADDR_BPP,    32'd0, psu_pkg::FILT_SUB,   '0},
      '{ROW_BYTE,    psu_pkg::ADDR_BPP,    32'd0, 8'hff, '0},
      '{ROW_BYTE,    psu_pkg::ADDR_BPP,    32'd0, 8'h02, '0},
      '{ROW_BYTE,    psu_pkg::ADDR_BPP,    32'd0, psu_pkg::FILT_UP,    '0},
      '{ROW_BYTE,    psu_pkg::ADDR_BPP,    32'd0, 8'h10, '0},
      '{ROW_BYTE,    psu_pkg::ADDR_BPP,    32'd0, 8'hf0, '0},
      '{ROW_BYTE,    psu_pkg::ADDR_BPP,    32'd0, psu_pkg::FILT_AVG,   '0},
      '{ROW_BYTE,    psu_pkg::ADDR_BPP,    32'd0, 8'h7f, '0},
      '{ROW_BYTE,    psu_pkg::ADDR_BPP,    32'd0, 8'h81, '0},
      '{ROW_BYTE,    psu_pkg::ADDR_BPP,    32'd0, psu_pkg::FILT_PAETH, '0},
      '{ROW_BYTE,    psu_pkg::ADDR_BPP,    32'd0, 8'h05, '0},
      '{ROW_BYTE,    psu_pkg::ADDR_BPP,    32'd0, 8'hfa, '0},
      // zero registers act as one
      '{ROW_CSR,     psu_pkg::ADDR_BPP,    32'd0, 8'h00, '0},
      '{ROW_CSR,     psu_pkg::ADDR_WIDTH,  32'd0, 8'h00, '0},
      '{ROW_CSR,     psu_pkg::ADDR_HEIGHT, 32'd0, 8'h00, '0},
      '{ROW_BYTE,    psu_pkg::ADDR_BPP,    32'd0, 8'hff, '0},
      '{ROW_CHECKED, psu_pkg::ADDR_BPP,    32'd0, 8'h3c, '{8'h3c, 1'b1, 1'b1, 1'b1}},
      '{ROW_BYTE,    psu_pkg::ADDR_BPP,    32'd0, 8'd5,  '0},
      '{ROW_CHECKED, psu_pkg::ADDR_BPP,    32'd0, 8'hc3, '{8'hc3, 1'b1, 1'b1, 1'b1}}
   };

   task automatic report_error(input string msg);
      error_count++;
      if (error_count <= PRINT_CAP) begin
         $display("[%0t] error: %s", $realtime, msg);
      end
   endtask

   function automatic void reset_predictor();
      foreach (line_store[i]) line_store[i] = '0;
      left_hist   = '{default: '0};
      upleft_hist = '{default: '0};
      row_filter  = psu_pkg::FILT_NONE;
      byte_pos    = 0;
      row_count   = 0;
      first_row   = 1'b1;
      bpp_reg     = 3'd4;
      width_reg   = 13'd1;
      height_reg  = 16'd1;
   endfunction

   function automatic logic [psu_pkg::BYTE_W-1:0] paeth_pick(input int a, input int b,
                                                             input int c);
      int p;
      int pa;
      int pb;
      int pc;
      p  = a + b - c;
      pa = (p > a) ? p - a : a - p;
      pb = (p > b) ? p - b : b - p;
      pc = (p > c) ? p - c : c - p;
      if (pa <= pb && pa <= pc) return 8'(a);
      if (pb <= pc) return 8'(b);
      return 8'(c);
   endfunction

   // returns 1 when the byte is a data byte and fills in its reconstructed pixel
   function automatic bit unfilter_byte(input logic [psu_pkg::BYTE_W-1:0] x,
                                        output pixel_type r);
      int unsigned                bpp;
      int unsigned                len;
      int unsigned                height;
      int unsigned                idx;
      logic [psu_pkg::BYTE_W-1:0] a;
      logic [psu_pkg::BYTE_W-1:0] b;
      logic [psu_pkg::BYTE_W-1:0] c;
      logic [psu_pkg::BYTE_W-1:0] pred;
      bit                         bad;
      bit                         row_done;
      bit                         last_row;
      r      = '0;
      bpp    = (bpp_reg == 0) ? 1 :
               ((bpp_reg > psu_pkg::MAX_BPP) ? psu_pkg::MAX_BPP : bpp_reg);
      len    = ((width_reg == 0) ? 1 :
               ((width_reg > psu_pkg::MAX_WIDTH) ? psu_pkg::MAX_WIDTH : width_reg)) * bpp;
      height = (height_reg == 0) ? 1 : height_reg;
      if (byte_pos == 0) begin
         row_filter  = x;
         left_hist   = '{default: '0};
         upleft_hist = '{default: '0};
         byte_pos    = 1;
         return 1'b0;
      end
      idx = byte_pos - 1;
      a   = left_hist[bpp-1];
      c   = upleft_hist[bpp-1];
      b   = (!first_row && idx < psu_pkg::STORE_DEPTH) ? line_store[idx] : '0;
      bad = 1'b0;
      case (row_filter)
         psu_pkg::FILT_NONE:  pred = '0;
         psu_pkg::FILT_SUB:   pred = a;
         psu_pkg::FILT_UP:    pred = b;
         psu_pkg::FILT_AVG:   pred = 8'((int'(a) + int'(b)) >> 1);
         psu_pkg::FILT_PAETH: pred = paeth_pick(a, b, c);
         default: begin
            pred = '0;
            bad  = 1'b1;
         end
      endcase
      r.pixel = x + pred;
      for (int i = psu_pkg::MAX_BPP - 1; i > 0; i--) begin
         left_hist[i]   = left_hist[i-1];
         upleft_hist[i] = upleft_hist[i-1];
      end
      left_hist[0]   = r.pixel;
      upleft_hist[0] = b;
      if (idx < psu_pkg::STORE_DEPTH) line_store[idx] = r.pixel;
      row_done = (idx + 1 >= len);
      last_row = (row_count + 1 >= height);
      if (row_done) begin
         byte_pos = 0;
         if (last_row) begin
            row_count = 0;
            first_row = 1'b1;
         end else begin
            row_count = (row_count + 1) & 32'hffff;
            first_row = 1'b0;
         end
      end else begin
         byte_pos = (byte_pos + 1) & 32'h7fff;
      end
      r.row_end    = row_done;
      r.image_end  = row_done && last_row;
      r.bad_filter = bad;
      return 1'b1;
   endfunction

   task automatic send_byte(input logic [psu_pkg::BYTE_W-1:0] data, input bit typed,
                            input pixel_type want);
      pixel_type r;
      if (req_gap_pct != 0 && $urandom_range(99) < req_gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(5, 1)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      do @(posedge clock); while (req_tready !== 1'b1);
      sent_requests++;
      if (unfilter_byte(data, r)) pending_pixels.push_back(typed ? want : r);
   endtask

   // lets every outstanding pixel come back before registers are touched
   task automatic wait_idle();
      int unsigned waited;
      req_tvalid <= 1'b0;
      waited = 0;
      while (pending_pixels.size() != 0 && waited < DRAIN_CYCLES) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_pixels.size() != 0) begin
         report_error($sformatf("%0d responses never arrived", pending_pixels.size()));
         pending_pixels.delete();
      end
   endtask

   // write, then read back over the same port
   task automatic csr_write(input logic [psu_pkg::ADDR_W-1:0] addr,
                            input logic [psu_pkg::DATA_W-1:0] value);
      logic [psu_pkg::DATA_W-1:0] stored;
      case (addr)
         psu_pkg::ADDR_BPP: begin
            bpp_reg = value[psu_pkg::BPP_RAW_W-1:0];
            stored  = psu_pkg::DATA_W'(bpp_reg);
         end
         psu_pkg::ADDR_WIDTH: begin
            width_reg = value[psu_pkg::WIDTH_W-1:0];
            stored    = psu_pkg::DATA_W'(width_reg);
         end
         default: begin
            height_reg = value[psu_pkg::HEIGHT_W-1:0];
            stored     = psu_pkg::DATA_W'(height_reg);
         end
      endcase
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== stored) begin
         report_error($sformatf("register %0h reads %0h, want %0h", addr, csr_prdata, stored));
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_writes++;
   endtask

   function automatic logic [psu_pkg::BYTE_W-1:0] next_request();
      if (byte_pos == 0) begin
         if ($urandom_range(99) < 85) return 8'($urandom_range(int'(psu_pkg::FILT_PAETH)));
         return 8'($urandom_range(255, 5));
      end
      return 8'($urandom());
   endfunction

   task automatic run_phase(input int unsigned count);
      repeat (count) send_byte(next_request(), 1'b0, '0);
   endtask

   task automatic random_config();
      int unsigned pick;
      int unsigned roll;
      pick = $urandom_range(7, 1);
      if (pick[0]) begin
         csr_write(psu_pkg::ADDR_BPP,
                   ($urandom_range(3) != 0) ? $urandom_range(4, 1) : $urandom_range(7));
      end
      if (pick[1]) begin
         roll = $urandom_range(9);
         csr_write(psu_pkg::ADDR_WIDTH, (roll < 8) ? $urandom_range(8, 1) :
                                        (roll == 8) ? 0 : $urandom_range(16, 9));
      end
      if (pick[2]) begin
         roll = $urandom_range(9);
         csr_write(psu_pkg::ADDR_HEIGHT, (roll < 6) ? $urandom_range(4, 1) :
                                         (roll == 6) ? 0 :
                                         (roll == 7) ? 32'hffff : $urandom_range(65535, 5));
      end
   endtask

   function automatic int unsigned pick_idle_pct();
      int unsigned roll;
      if (calm) return 0;
      roll = $urandom_range(2);
      return (roll == 0) ? 0 : ((roll == 1) ? 10 : 35);
   endfunction

   // response side back-pressure in random bursts, none while calm
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b1;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (!calm && rsp_stall_pct != 0 && $urandom_range(99) < rsp_stall_pct) begin
         stall_left <= $urandom_range(4);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // tuser: [0] image end, [1] bad filter
   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         if (pending_pixels.size() == 0) begin
            report_error($sformatf("response %02h with nothing outstanding", rsp_tdata));
         end else begin
            want_pixel = pending_pixels.pop_front();
            checked_responses++;
            if (rsp_tdata !== want_pixel.pixel) begin
               report_error($sformatf("pixel byte %02h, want %02h", rsp_tdata, want_pixel.pixel));
            end
            if (rsp_tlast !== want_pixel.row_end) begin
               report_error($sformatf("row end %b, want %b", rsp_tlast, want_pixel.row_end));
            end
            if (rsp_tuser[0] !== want_pixel.image_end) begin
               report_error($sformatf("image end %b, want %b", rsp_tuser[0],
                                      want_pixel.image_end));
            end
            if (rsp_tuser[1] !== want_pixel.bad_filter) begin
               report_error($sformatf("bad filter %b, want %b", rsp_tuser[1],
                                      want_pixel.bad_filter));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("timed out after %0d cycles", cycle_count);
         $display("png_scanline_unfilter regression: fail");
         $finish;
      end
   end

   initial begin
      int unsigned count;
      reset_predictor();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_stim[i]) begin
         case (directed_stim[i].kind)
            ROW_CSR: begin
               wait_idle();
               csr_write(directed_stim[i].addr, directed_stim[i].value);
            end
            ROW_BYTE: send_byte(directed_stim[i].data, 1'b0, '0);
            default: send_byte(directed_stim[i].data, 1'b1, directed_stim[i].want);
         endcase
      end

      // oversized registers clamp, the row runs on without ending and fills the
      // entries that later short rows read from above
      wait_idle();
      csr_write(psu_pkg::ADDR_BPP, 32'd7);
      csr_write(psu_pkg::ADDR_WIDTH, 32'd8191);
      csr_write(psu_pkg::ADDR_HEIGHT, 32'd1);
      run_phase(1 + PREFILL_BYTES);

      // shrinking the row below the current position ends it on the next byte
      wait_idle();
      csr_write(psu_pkg::ADDR_WIDTH, 32'd16);
      run_phase(1);

      // short images, registers changed at any row or byte boundary
      while (random_requests < RANDOM_REQUESTS) begin
         calm = (random_requests >= CALM_FROM);
         wait_idle();
         random_config();
         req_gap_pct   = pick_idle_pct();
         rsp_stall_pct = pick_idle_pct();
         count = $urandom_range(60, 1);
         run_phase(count);
         random_requests += count;
      end
      wait_idle();

      $display("%0d requests (%0d random) gave %0d checked responses",
               sent_requests, random_requests, checked_responses);
      $display("%0d register writes incl. zero and out-of-range sizes, all five filters",
               csr_writes);
      if (error_count == 0) begin
         $display("png_scanline_unfilter regression: pass");
      end else begin
         $display("%0d errors", error_count);
         $display("png_scanline_unfilter regression: fail");
      end
      $finish;
   end

endmodule
